// ===== rtl/isbn_pkg.sv =====
`default_nettype none
package isbn_pkg;

  localparam int unsigned ISBN_FIFO_DEPTH = 4;

  localparam int unsigned VALUE_W  = 24;
  localparam int unsigned PROD_W   = VALUE_W + 4;
  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  localparam int unsigned STR_LEN = 22;
  localparam int unsigned NUM_DIGITS = 13;

  // field positions
  localparam logic [2:0] FLD_PREFIX   = 3'd0;
  localparam logic [2:0] FLD_BOOKLAND = 3'd1;
  localparam logic [2:0] FLD_GROUP    = 3'd2;
  localparam logic [2:0] FLD_PUB      = 3'd3;
  localparam logic [2:0] FLD_TITLE    = 3'd4;
  localparam logic [2:0] FLD_CHECK    = 3'd5;

  // fail reasons
  localparam logic [2:0] RSN_OK       = 3'd0;
  localparam logic [2:0] RSN_PREFIX   = 3'd1;
  localparam logic [2:0] RSN_LENGTH   = 3'd2;
  localparam logic [2:0] RSN_BOOKLAND = 3'd3;
  localparam logic [2:0] RSN_GROUP    = 3'd4;
  localparam logic [2:0] RSN_PUB      = 3'd5;
  localparam logic [2:0] RSN_DIGITS   = 3'd6;

  typedef enum logic [2:0] {
    K_DIGIT,
    K_DASH,
    K_SPACE,
    K_LET_I,
    K_LET_S,
    K_LET_B,
    K_LET_N,
    K_OTHER
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] digit;
    logic       last;
  } token_t;

  function automatic logic [2:0] fault_of_field(input logic [2:0] f);
    logic [2:0] r;
    case (f)
      FLD_PREFIX:   r = RSN_PREFIX;
      FLD_BOOKLAND: r = RSN_BOOKLAND;
      FLD_GROUP:    r = RSN_GROUP;
      FLD_PUB:      r = RSN_PUB;
      default:      r = RSN_DIGITS;
    endcase
    return r;
  endfunction

  function automatic kind_t prefix_letter(input logic [2:0] pos);
    kind_t k;
    case (pos)
      3'd0:    k = K_LET_I;
      3'd1:    k = K_LET_S;
      3'd2:    k = K_LET_B;
      3'd3:    k = K_LET_N;
      default: k = K_OTHER;
    endcase
    return k;
  endfunction

  function automatic logic group_a_ok(input logic [VALUE_W-1:0] v);
    return (v <= 24'd5) || (v == 24'd7) ||
           (v >= 24'd80 && v <= 24'd94) ||
           (v >= 24'd600 && v <= 24'd649) ||
           (v >= 24'd950 && v <= 24'd989) ||
           (v >= 24'd9900 && v <= 24'd9989) ||
           (v >= 24'd99900 && v <= 24'd99999);
  endfunction

  function automatic logic publisher_ok(input logic [VALUE_W-1:0] v);
    return (v <= 24'd19) ||
           (v >= 24'd200 && v <= 24'd699) ||
           (v >= 24'd7000 && v <= 24'd8499) ||
           (v >= 24'd85000 && v <= 24'd89999) ||
           (v >= 24'd900000 && v <= 24'd949999) ||
           (v >= 24'd9500000 && v <= 24'd9999999);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/isbn_front.sv =====
`default_nettype none
module isbn_front import isbn_pkg::*; (
  input  wire logic       in_valid,
  input  wire logic [7:0] in_char_in,
  input  wire logic       in_is_last,
  input  wire logic       q_full,
  output logic            in_stall,
  output logic            q_push,
  output token_t          q_tok
);

  logic [7:0] dsub;

  assign dsub = in_char_in - 8'h30;

  always_comb begin
    q_tok.digit = dsub[3:0];
    q_tok.last  = in_is_last;
    if (in_char_in >= 8'h30 && in_char_in <= 8'h39) begin
      q_tok.kind = K_DIGIT;
    end else begin
      case (in_char_in)
        8'h2D:   q_tok.kind = K_DASH;
        8'h20:   q_tok.kind = K_SPACE;
        8'h49:   q_tok.kind = K_LET_I;
        8'h53:   q_tok.kind = K_LET_S;
        8'h42:   q_tok.kind = K_LET_B;
        8'h4E:   q_tok.kind = K_LET_N;
        default: q_tok.kind = K_OTHER;
      endcase
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule
`default_nettype wire

// ===== rtl/isbn_fifo.sv =====
`default_nettype none
module isbn_fifo import isbn_pkg::*; #(
  parameter int unsigned DEPTH = ISBN_FIFO_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire token_t push_tok,
  input  wire logic   pop,
  output logic        full,
  output logic        nonempty,
  output token_t      head_tok
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  token_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == FULL_CNT);
  assign nonempty = (count_r != '0);
  assign head_tok = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_tok;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push while queue full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> nonempty)
    else $error("pop while queue empty");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("count did not follow push");

endmodule
`default_nettype wire

// ===== rtl/isbn_back.sv =====
`default_nettype none
module isbn_back import isbn_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   q_nonempty,
  input  wire token_t q_tok,
  output logic        q_pop,
  output logic        out_valid,
  input  wire logic   out_stall,
  output logic        out_valid_res,
  output logic [2:0]  out_fail_reason
);

  logic [2:0]         field_index_r, field_index_nxt;
  logic [4:0]         char_count_r, char_count_nxt;
  logic [VALUE_W-1:0] field_value_r, field_value_nxt;
  logic [2:0]         field_chars_r, field_chars_nxt;
  logic [3:0]         digit_count_r, digit_count_nxt;
  logic [3:0]         wsum_r, wsum_nxt;
  logic [2:0]         first_fault_r, first_fault_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               res_valid_r, res_valid_nxt;
  logic [2:0]         reason_r, reason_nxt;

  logic               out_free;
  logic [PROD_W-1:0]  prod;
  logic [5:0]         wsum_add;
  logic [5:0]         wd;
  logic               close_ok;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = q_nonempty && (!q_tok.last || out_free);

  assign prod = {field_value_r, 3'b000} + {3'b000, field_value_r, 1'b0}
              + PROD_W'(q_tok.digit);
  assign wd   = digit_count_r[0] ? (6'(q_tok.digit) + {1'b0, q_tok.digit, 1'b0})
                                 : 6'(q_tok.digit);
  assign wsum_add = 6'(wsum_r) + wd;

  always_comb begin
    close_ok = (field_chars_r != 3'd0);
    case (field_index_r)
      FLD_BOOKLAND: close_ok = close_ok && field_chars_r == 3'd3 &&
                               (field_value_r == 24'd978 || field_value_r == 24'd979);
      FLD_GROUP:    close_ok = close_ok && group_a_ok(field_value_r);
      FLD_PUB:      close_ok = close_ok && publisher_ok(field_value_r);
      default:      close_ok = close_ok;
    endcase
  end

  // per-byte state update
  always_comb begin
    field_index_nxt = field_index_r;
    char_count_nxt  = (char_count_r == 5'd31) ? char_count_r : char_count_r + 1'b1;
    field_value_nxt = field_value_r;
    field_chars_nxt = field_chars_r;
    digit_count_nxt = digit_count_r;
    wsum_nxt        = wsum_r;
    first_fault_nxt = first_fault_r;
    if (first_fault_r == RSN_OK) begin
      if (field_index_r == FLD_PREFIX) begin
        if (q_tok.kind == K_SPACE) begin
          if (field_chars_r == 3'd4) begin
            field_index_nxt = FLD_BOOKLAND;
            field_chars_nxt = 3'd0;
          end else begin
            first_fault_nxt = RSN_PREFIX;
          end
        end else if (field_chars_r < 3'd4 && q_tok.kind == prefix_letter(field_chars_r)) begin
          field_chars_nxt = field_chars_r + 1'b1;
        end else begin
          first_fault_nxt = RSN_PREFIX;
        end
      end else if (q_tok.kind == K_DIGIT) begin
        if (wsum_add >= 6'd30) begin
          wsum_nxt = 4'(wsum_add - 6'd30);
        end else if (wsum_add >= 6'd20) begin
          wsum_nxt = 4'(wsum_add - 6'd20);
        end else if (wsum_add >= 6'd10) begin
          wsum_nxt = 4'(wsum_add - 6'd10);
        end else begin
          wsum_nxt = 4'(wsum_add);
        end
        if (digit_count_r != 4'd15) begin
          digit_count_nxt = digit_count_r + 1'b1;
        end
        if (field_chars_r != 3'd7) begin
          field_chars_nxt = field_chars_r + 1'b1;
        end
        field_value_nxt = (prod[PROD_W-1:VALUE_W] != '0) ? VALUE_MAX
                                                         : prod[VALUE_W-1:0];
      end else if (q_tok.kind == K_DASH && field_index_r < FLD_CHECK) begin
        if (close_ok) begin
          field_index_nxt = field_index_r + 1'b1;
          field_value_nxt = '0;
          field_chars_nxt = 3'd0;
        end else begin
          first_fault_nxt = fault_of_field(field_index_r);
        end
      end else begin
        first_fault_nxt = fault_of_field(field_index_r);
      end
    end
  end

  // end-of-string verdict
  always_comb begin
    logic [2:0] ff;
    ff = first_fault_nxt;
    if (ff == RSN_OK) begin
      if (field_index_nxt != FLD_CHECK) begin
        ff = fault_of_field(field_index_nxt);
      end else if (field_chars_nxt == 3'd0) begin
        ff = RSN_DIGITS;
      end
    end
    if (ff == RSN_PREFIX) begin
      reason_nxt = RSN_PREFIX;
    end else if (char_count_nxt != 5'(STR_LEN)) begin
      reason_nxt = RSN_LENGTH;
    end else if (ff != RSN_OK) begin
      reason_nxt = ff;
    end else if (digit_count_nxt != 4'(NUM_DIGITS) || wsum_nxt != 4'd0) begin
      reason_nxt = RSN_DIGITS;
    end else begin
      reason_nxt = RSN_OK;
    end
    res_valid_nxt = (reason_nxt == RSN_OK);
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (q_pop && q_tok.last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_index_r <= FLD_PREFIX;
      char_count_r  <= '0;
      field_value_r <= '0;
      field_chars_r <= '0;
      digit_count_r <= '0;
      wsum_r        <= '0;
      first_fault_r <= RSN_OK;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        if (q_tok.last) begin
          field_index_r <= FLD_PREFIX;
          char_count_r  <= '0;
          field_value_r <= '0;
          field_chars_r <= '0;
          digit_count_r <= '0;
          wsum_r        <= '0;
          first_fault_r <= RSN_OK;
        end else begin
          field_index_r <= field_index_nxt;
          char_count_r  <= char_count_nxt;
          field_value_r <= field_value_nxt;
          field_chars_r <= field_chars_nxt;
          digit_count_r <= digit_count_nxt;
          wsum_r        <= wsum_nxt;
          first_fault_r <= first_fault_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_tok.last) begin
      res_valid_r <= res_valid_nxt;
      reason_r    <= reason_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_valid_res   = res_valid_r;
  assign out_fail_reason = reason_r;

  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_tok.last) |=> (field_index_r == FLD_PREFIX && char_count_r == 5'd0 &&
                               first_fault_r == RSN_OK))
    else $error("state not cleared after string end");

  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && !q_tok.last && first_fault_r != RSN_OK) |=>
      (first_fault_r == $past(first_fault_r) && field_index_r == $past(field_index_r)))
    else $error("state moved after a fault");

  a_res_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_valid_r == (reason_r == RSN_OK)))
    else $error("valid flag disagrees with reason");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !(q_pop && q_tok.last))
    else $error("result overwritten while stalled");

endmodule
`default_nettype wire

// ===== rtl/isbn13_string_validator.sv =====
// ISBN-13 string checker.
// Input channel: one ASCII byte per transfer (in_char_in), in_is_last set on
// the final byte of a string "ISBN 978-A-B-C-D". Output channel: one result
// transfer per string, out_valid_res (1 = valid ISBN-13) and out_fail_reason
// (0 ok, 1 prefix, 2 length, 3 bookland, 4 group, 5 publisher, 6 digits or
// checksum). Bytes without in_is_last give no result.
// Throughput: one byte per clock unless in_stall or a held result stops the
// flow. A front classifier writes each byte into a small queue (FIFO_DEPTH
// entries) and the checker pops one entry per clock while the queue is nonempty.
// With the queue empty the last byte goes through the queue write and then the
// result register; each byte still queued ahead of it delays the result further.
// When out_stall is high the result holds; the checker keeps consuming bytes of
// the next string and stops only at its last byte, then in_stall rises once the
// queue fills. Reset (rst_n low, synchronous) empties the queue, drops any
// pending result and returns the checker to the start of a string.
`default_nettype none
module isbn13_string_validator import isbn_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = ISBN_FIFO_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_in,
  input  wire logic       in_is_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_valid_res,
  output logic [2:0]      out_fail_reason
);

  logic   q_full;
  logic   q_push;
  logic   q_pop;
  logic   q_nonempty;
  token_t push_tok;
  token_t head_tok;

  isbn_front u_front (
    .in_valid   (in_valid),
    .in_char_in (in_char_in),
    .in_is_last (in_is_last),
    .q_full     (q_full),
    .in_stall   (in_stall),
    .q_push     (q_push),
    .q_tok      (push_tok)
  );

  isbn_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_tok (push_tok),
    .pop      (q_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head_tok (head_tok)
  );

  isbn_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_nonempty      (q_nonempty),
    .q_tok           (head_tok),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_valid_res   (out_valid_res),
    .out_fail_reason (out_fail_reason)
  );

endmodule
`default_nettype wire
